/* rtl/dual_pia_register_block_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the dual PIA register block
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_PIA_REGISTER_BLOCK_UNIT_MACROS_SVH
`define DUAL_PIA_REGISTER_BLOCK_UNIT_MACROS_SVH

// antecedent in this cycle implies consequent in the next cycle
`define DPIA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define DPIA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/dpia_pkg.sv */
// ----------------------------------------------------------------------------
// dpia_pkg
// Function codes, register offsets and masks of the dual PIA register block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpia_pkg;

    // function codes of an input beat
    localparam logic [3:0] FUNC_PIA0_RD  = 4'd0;
    localparam logic [3:0] FUNC_PIA0_WR  = 4'd1;
    localparam logic [3:0] FUNC_PIA1_RD  = 4'd2;
    localparam logic [3:0] FUNC_PIA1_WR  = 4'd3;
    localparam logic [3:0] FUNC_HSYNC    = 4'd4;
    localparam logic [3:0] FUNC_FSYNC    = 4'd5;
    localparam logic [3:0] FUNC_CART_SET = 4'd6;
    localparam logic [3:0] FUNC_CART_CHK = 4'd7;
    localparam logic [3:0] FUNC_CASS_IN  = 4'd8;

    // register offsets within one adapter
    localparam logic [1:0] OFS_DATA_A = 2'd0;
    localparam logic [1:0] OFS_CTRL_A = 2'd1;
    localparam logic [1:0] OFS_DATA_B = 2'd2;
    localparam logic [1:0] OFS_CTRL_B = 2'd3;

    // sync edge codes
    localparam logic [1:0] PHASE_FALL = 2'd0;
    localparam logic [1:0] PHASE_RISE = 2'd1;
    localparam logic [1:0] PHASE_ANY  = 2'd2;

    // control register bits and masks
    localparam logic [7:0] CTRL_WR_MASK  = 8'h3F;
    localparam logic [7:0] CTRL_FLAG1    = 8'h80;
    localparam int         CTRL_IRQ_EN   = 0;
    localparam int         CTRL_POLARITY = 1;
    localparam int         CTRL_DDR_SEL  = 2;
    localparam int         CTRL_CA2_OUT  = 3;

endpackage

/* rtl/dual_pia_register_block_unit.sv */
// Dual PIA register block.
// A beat accepted at one edge shows its result on the output port right
// after that edge; throughput is one beat per cycle while the output is not stalled.
// The input side is ready whenever the result register is empty or being taken.
// Reset (rst_n low, asynchronous) clears all adapter registers, the sample
// stores, the cartridge level and the output valid flag.
// ----------------------------------------------------------------------------
// dual_pia_register_block_unit
// Two 6821-style adapters: data, direction and control registers, sync and
// cartridge interrupt flags, DAC / cassette / sound sample stores.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_pia_register_block_unit
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] func,
    input  logic [1:0] port,
    input  logic [7:0] wdata,
    input  logic [1:0] phase,
    input  logic [7:0] key_column,
    input  logic       cart_line,
    input  logic [7:0] cass_in,

    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] rdata,
    output logic       irq_raise,
    output logic       firq_raise,
    output logic       firq_drop,
    output logic [4:0] video_mode,
    output logic [6:0] audio_level,
    output logic [7:0] cass_out,
    output logic [7:0] sound_bit_level,
    output logic       motor_on,
    output logic [1:0] mux_select,
    output logic [7:0] key_strobe
);
    import dpia_pkg::*;

    // ------------------------------------------------------------------
    // Adapter state. Adapter 0 data A is never read back (a data read
    // returns the keyboard column), so it is not stored.
    // ------------------------------------------------------------------
    logic [7:0] p0_cra_reg,  p0_cra_next;
    logic [7:0] p0_ddra_reg, p0_ddra_next;
    logic [7:0] p0_crb_reg,  p0_crb_next;
    logic [7:0] p0_orb_reg,  p0_orb_next;
    logic [7:0] p0_ddrb_reg, p0_ddrb_next;

    logic [7:0] p1_cra_reg,  p1_cra_next;
    logic [7:0] p1_ora_reg,  p1_ora_next;
    logic [7:0] p1_ddra_reg, p1_ddra_next;
    logic [7:0] p1_crb_reg,  p1_crb_next;
    logic [7:0] p1_orb_reg,  p1_orb_next;
    logic [7:0] p1_ddrb_reg, p1_ddrb_next;

    // sample stores hold only their meaningful bits (DAC bits 7:2, sound bit)
    logic [5:0] audio_reg, audio_next;
    logic [5:0] cass_reg,  cass_next;
    logic       sound_reg, sound_next;
    logic       cart_level_reg, cart_level_next;

    // result register (per-beat part); the rest of the beat reads the state
    logic       out_valid_reg, out_valid_next;
    logic [7:0] rdata_reg, rdata_next;
    logic       irq_reg,   irq_next;
    logic       firq_up_reg,   firq_up_next;
    logic       firq_down_reg, firq_down_next;

    logic       accept;
    logic       sync_act;
    logic [1:0] mux_now;

    // A new beat enters when the result slot is empty or drains this cycle.
    // State only changes on accept, so while a result waits the state
    // still shows that beat's view.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign mux_now  = {p0_crb_reg[CTRL_CA2_OUT], p0_cra_reg[CTRL_CA2_OUT]};

    always_comb
    begin
        p0_cra_next     = p0_cra_reg;
        p0_ddra_next    = p0_ddra_reg;
        p0_crb_next     = p0_crb_reg;
        p0_orb_next     = p0_orb_reg;
        p0_ddrb_next    = p0_ddrb_reg;
        p1_cra_next     = p1_cra_reg;
        p1_ora_next     = p1_ora_reg;
        p1_ddra_next    = p1_ddra_reg;
        p1_crb_next     = p1_crb_reg;
        p1_orb_next     = p1_orb_reg;
        p1_ddrb_next    = p1_ddrb_reg;
        audio_next      = audio_reg;
        cass_next       = cass_reg;
        sound_next      = sound_reg;
        cart_level_next = cart_level_reg;
        rdata_next      = 8'h00;
        irq_next        = 1'b0;
        firq_up_next    = 1'b0;
        firq_down_next  = 1'b0;
        sync_act        = 1'b0;

        case (func)
            FUNC_PIA0_RD:
            begin
                case (port)
                    OFS_DATA_A:
                    begin
                        if (p0_cra_reg[CTRL_DDR_SEL])
                        begin
                            // data read: keyboard column, clears both flags
                            rdata_next  = key_column;
                            p0_cra_next = p0_cra_reg & CTRL_WR_MASK;
                        end
                        else
                        begin
                            rdata_next = p0_ddra_reg;
                        end
                    end
                    OFS_CTRL_A: rdata_next = p0_cra_reg;
                    OFS_DATA_B:
                    begin
                        if (p0_crb_reg[CTRL_DDR_SEL])
                        begin
                            rdata_next  = p0_orb_reg & p0_ddrb_reg;
                            p0_crb_next = p0_crb_reg & CTRL_WR_MASK;
                        end
                        else
                        begin
                            rdata_next = p0_ddrb_reg;
                        end
                    end
                    default: rdata_next = p0_crb_reg;
                endcase
            end
            FUNC_PIA0_WR:
            begin
                case (port)
                    OFS_DATA_A:
                    begin
                        if (!p0_cra_reg[CTRL_DDR_SEL])
                        begin
                            p0_ddra_next = wdata;
                        end
                    end
                    OFS_CTRL_A: p0_cra_next = wdata & CTRL_WR_MASK;
                    OFS_DATA_B:
                    begin
                        if (p0_crb_reg[CTRL_DDR_SEL])
                        begin
                            p0_orb_next = wdata;
                        end
                        else
                        begin
                            p0_ddrb_next = wdata;
                        end
                    end
                    default: p0_crb_next = wdata & CTRL_WR_MASK;
                endcase
            end
            FUNC_PIA1_RD:
            begin
                case (port)
                    OFS_DATA_A:
                    begin
                        if (p1_cra_reg[CTRL_DDR_SEL])
                        begin
                            // side A data comes back unmasked
                            rdata_next  = p1_ora_reg;
                            p1_cra_next = p1_cra_reg & CTRL_WR_MASK;
                        end
                        else
                        begin
                            rdata_next = p1_ddra_reg;
                        end
                    end
                    OFS_CTRL_A: rdata_next = p1_cra_reg;
                    OFS_DATA_B:
                    begin
                        if (p1_crb_reg[CTRL_DDR_SEL])
                        begin
                            rdata_next  = p1_orb_reg & p1_ddrb_reg;
                            p1_crb_next = p1_crb_reg & CTRL_WR_MASK;
                        end
                        else
                        begin
                            rdata_next = p1_ddrb_reg;
                        end
                    end
                    default: rdata_next = p1_crb_reg;
                endcase
            end
            FUNC_PIA1_WR:
            begin
                case (port)
                    OFS_DATA_A:
                    begin
                        if (p1_cra_reg[CTRL_DDR_SEL])
                        begin
                            p1_ora_next = wdata;
                            // DAC sample only when the mux points at the DAC;
                            // side B CA2 picks audio or cassette
                            if (mux_now == 2'b00)
                            begin
                                if (p1_crb_reg[CTRL_CA2_OUT])
                                begin
                                    audio_next = wdata[7:2];
                                end
                                else
                                begin
                                    cass_next = wdata[7:2];
                                end
                            end
                        end
                        else
                        begin
                            p1_ddra_next = wdata;
                        end
                    end
                    OFS_CTRL_A: p1_cra_next = wdata & CTRL_WR_MASK;
                    OFS_DATA_B:
                    begin
                        if (p1_crb_reg[CTRL_DDR_SEL])
                        begin
                            p1_orb_next = wdata & p1_ddrb_reg;
                            sound_next  = wdata[1] & p1_ddrb_reg[1];
                        end
                        else
                        begin
                            p1_ddrb_next = wdata;
                        end
                    end
                    default: p1_crb_next = wdata & CTRL_WR_MASK;
                endcase
            end
            FUNC_HSYNC:
            begin
                case (phase)
                    PHASE_FALL: sync_act = !p0_cra_reg[CTRL_POLARITY];
                    PHASE_RISE: sync_act = p0_cra_reg[CTRL_POLARITY];
                    PHASE_ANY:  sync_act = 1'b1;
                    default:    sync_act = 1'b0;
                endcase
                if (sync_act)
                begin
                    p0_cra_next = p0_cra_reg | CTRL_FLAG1;
                    irq_next    = p0_cra_reg[CTRL_IRQ_EN];
                end
            end
            FUNC_FSYNC:
            begin
                case (phase)
                    PHASE_FALL: sync_act = 1'b1;
                    PHASE_RISE: sync_act = p0_crb_reg[CTRL_POLARITY];
                    default:    sync_act = 1'b0;
                endcase
                if (sync_act)
                begin
                    p0_crb_next = p0_crb_reg | CTRL_FLAG1;
                    irq_next    = p0_crb_reg[CTRL_IRQ_EN];
                end
            end
            FUNC_CART_SET:
            begin
                cart_level_next = cart_line;
            end
            FUNC_CART_CHK:
            begin
                // cartridge line held low: flag on side B, FIRQ follows enable
                if (!cart_level_reg)
                begin
                    p1_crb_next    = p1_crb_reg | CTRL_FLAG1;
                    firq_up_next   = p1_crb_reg[CTRL_IRQ_EN];
                    firq_down_next = !p1_crb_reg[CTRL_IRQ_EN];
                end
            end
            FUNC_CASS_IN:
            begin
                // comparator: sample above mid-scale reads as a one
                p1_ora_next = {p1_ora_reg[7:1], cass_in[7]};
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_cra_reg     <= '0;
            p0_ddra_reg    <= '0;
            p0_crb_reg     <= '0;
            p0_orb_reg     <= '0;
            p0_ddrb_reg    <= '0;
            p1_cra_reg     <= '0;
            p1_ora_reg     <= '0;
            p1_ddra_reg    <= '0;
            p1_crb_reg     <= '0;
            p1_orb_reg     <= '0;
            p1_ddrb_reg    <= '0;
            audio_reg      <= '0;
            cass_reg       <= '0;
            sound_reg      <= 1'b0;
            cart_level_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                p0_cra_reg     <= p0_cra_next;
                p0_ddra_reg    <= p0_ddra_next;
                p0_crb_reg     <= p0_crb_next;
                p0_orb_reg     <= p0_orb_next;
                p0_ddrb_reg    <= p0_ddrb_next;
                p1_cra_reg     <= p1_cra_next;
                p1_ora_reg     <= p1_ora_next;
                p1_ddra_reg    <= p1_ddra_next;
                p1_crb_reg     <= p1_crb_next;
                p1_orb_reg     <= p1_orb_next;
                p1_ddrb_reg    <= p1_ddrb_next;
                audio_reg      <= audio_next;
                cass_reg       <= cass_next;
                sound_reg      <= sound_next;
                cart_level_reg <= cart_level_next;
            end
        end
    end

    // per-beat result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg     <= rdata_next;
            irq_reg       <= irq_next;
            firq_up_reg   <= firq_up_next;
            firq_down_reg <= firq_down_next;
        end
    end

    // ------------------------------------------------------------------
    // Result port: per-beat fields from the result register, the rest
    // straight from the updated adapter state.
    // ------------------------------------------------------------------
    assign out_valid       = out_valid_reg;
    assign rdata           = rdata_reg;
    assign irq_raise       = irq_reg;
    assign firq_raise      = firq_up_reg;
    assign firq_drop       = firq_down_reg;
    assign video_mode      = p1_orb_reg[7:3];
    assign audio_level     = {audio_reg, 1'b0};
    assign cass_out        = {cass_reg, 2'b00};
    assign sound_bit_level = {sound_reg, 7'b0000000};
    assign motor_on        = p1_cra_reg[CTRL_CA2_OUT];
    assign mux_select      = mux_now;
    assign key_strobe      = p0_orb_reg;

endmodule

/* rtl/dpia_checker.sv */
// ----------------------------------------------------------------------------
// dpia_checker
// Port-level assertions for the dual PIA register block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dual_pia_register_block_unit_macros.svh"

module dpia_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [3:0] func,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] rdata,
    input logic       irq_raise,
    input logic       firq_raise,
    input logic       firq_drop
);
    import dpia_pkg::*;

    // stalled result holds
    `DPIA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(rdata), "result changed while stalled")

    // every accepted beat shows its result in the next cycle
    `DPIA_ASSERT_NEXT(a_one_cycle, in_valid && in_ready, out_valid, "accepted beat produced no result")

    // only read accesses return data
    `DPIA_ASSERT_NEXT(a_rdata_zero, in_valid && in_ready && func != FUNC_PIA0_RD && func != FUNC_PIA1_RD, rdata == 8'h00, "nonzero rdata on a non-read beat")

    // IRQ only from sync beats
    `DPIA_ASSERT_NEXT(a_irq_src, in_valid && in_ready && func != FUNC_HSYNC && func != FUNC_FSYNC, !irq_raise, "IRQ raised by a non-sync beat")

    // FIRQ raise and drop are exclusive
    `DPIA_ASSERT_SAME(a_firq_excl, out_valid, !(firq_raise && firq_drop), "FIRQ raised and dropped together")

endmodule

bind dual_pia_register_block_unit dpia_checker u_dpia_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rdata      (rdata),
    .irq_raise  (irq_raise),
    .firq_raise (firq_raise),
    .firq_drop  (firq_drop)
);
